// File: design/acrmc_pkg.sv
// ----------------------------------------------------------------------------
// acrmc_pkg
// Shared types and constants for the associative cache miss classifier.
// ----------------------------------------------------------------------------
package acrmc_pkg;

  localparam int MAX_WAYS   = 16;
  localparam int WAY_IDX_W  = $clog2(MAX_WAYS);
  localparam int WAY_CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int HIST_DEPTH = 256;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);
  localparam int KEY_W      = 32;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    POL_FIFO  = 2'd0,
    POL_LRU   = 2'd1,
    POL_CLOCK = 2'd2,
    POL_SPARE = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_COMP = 2'd1,
    KIND_CAP  = 2'd2,
    KIND_RSVD = 2'd3
  } miss_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY = 1'd0,
    REG_WAYS   = 1'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    WOP_NONE,
    WOP_TRIM,
    WOP_LRU_HIT,
    WOP_REF_SET,
    WOP_FILL,
    WOP_SHIFT_IN,
    WOP_CLK_STEP,
    WOP_CLK_PLACE
  } way_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HIST,
    ST_MISS,
    ST_CLOCK,
    ST_RESULT
  } state_e;

  typedef struct packed {
    way_op_e              op;
    logic [KEY_W-1:0]     key;
    logic [WAY_CNT_W-1:0] ways;
  } way_cmd_t;

  typedef struct packed {
    logic                 found;
    logic [WAY_IDX_W-1:0] pos;
    logic                 full;
    logic                 hand_ref;
  } way_sts_t;

endpackage

// File: design/acrmc_ram.sv
// ----------------------------------------------------------------------------
// acrmc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module acrmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/acrmc_ways.sv
// ----------------------------------------------------------------------------
// acrmc_ways
// Cache entry store: parallel key match, LRU/FIFO order shifts, clock bits.
// ----------------------------------------------------------------------------
module acrmc_ways import acrmc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  way_cmd_t cmd_i,
  output way_sts_t sts_o
);

  logic [KEY_W-1:0]     keys_q [MAX_WAYS];
  logic [KEY_W-1:0]     keys_d [MAX_WAYS];
  logic [MAX_WAYS-1:0]  ref_q, ref_d;
  logic [WAY_CNT_W-1:0] cnt_q, cnt_d;
  logic [WAY_IDX_W-1:0] hand_q, hand_d;
  logic [WAY_IDX_W-1:0] pos;
  logic                 found;
  logic [WAY_IDX_W-1:0] hand_nxt;

  // first matching valid entry
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if ((WAY_CNT_W'(i) < cnt_q) && (keys_q[i] == cmd_i.key)) begin
        found = 1'b1;
        pos   = WAY_IDX_W'(i);
      end
    end
  end

  // hand advance modulo active ways
  assign hand_nxt = ({1'b0, hand_q} + WAY_CNT_W'(1) == cmd_i.ways) ? '0 : hand_q + 1'b1;

  always_comb begin
    keys_d = keys_q;
    ref_d  = ref_q;
    cnt_d  = cnt_q;
    hand_d = hand_q;
    case (cmd_i.op)
      WOP_TRIM: begin
        if (cnt_q > cmd_i.ways) cnt_d = cmd_i.ways;
        if ({1'b0, hand_q} >= cmd_i.ways) hand_d = '0;
      end
      WOP_LRU_HIT: begin
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (WAY_CNT_W'(i) + WAY_CNT_W'(1) == cnt_q) begin
            keys_d[i] = cmd_i.key;
          end else if (i < MAX_WAYS - 1 && WAY_IDX_W'(i) >= pos
                       && WAY_CNT_W'(i) + WAY_CNT_W'(1) < cnt_q) begin
            keys_d[i] = keys_q[(i + 1) % MAX_WAYS];
          end
        end
      end
      WOP_REF_SET: ref_d[pos] = 1'b1;
      WOP_FILL: begin
        keys_d[cnt_q[WAY_IDX_W-1:0]] = cmd_i.key;
        ref_d[cnt_q[WAY_IDX_W-1:0]]  = 1'b0;
        cnt_d = cnt_q + 1'b1;
      end
      WOP_SHIFT_IN: begin
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (WAY_CNT_W'(i) + WAY_CNT_W'(1) == cmd_i.ways) begin
            keys_d[i] = cmd_i.key;
          end else if (i < MAX_WAYS - 1 && WAY_CNT_W'(i) + WAY_CNT_W'(1) < cmd_i.ways) begin
            keys_d[i] = keys_q[(i + 1) % MAX_WAYS];
          end
        end
      end
      WOP_CLK_STEP: begin
        ref_d[hand_q] = 1'b0;
        hand_d = hand_nxt;
      end
      WOP_CLK_PLACE: begin
        keys_d[hand_q] = cmd_i.key;
        ref_d[hand_q]  = 1'b0;
        hand_d = hand_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q  <= '0;
      cnt_q  <= '0;
      hand_q <= '0;
    end else begin
      ref_q  <= ref_d;
      cnt_q  <= cnt_d;
      hand_q <= hand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    keys_q <= keys_d;
  end

  assign sts_o.found    = found;
  assign sts_o.pos      = pos;
  assign sts_o.full     = (cnt_q >= cmd_i.ways);
  assign sts_o.hand_ref = ref_q[hand_q];

endmodule

// File: design/assoc_cache_replacement_miss_classifier.sv
// ----------------------------------------------------------------------------
// assoc_cache_replacement_miss_classifier
// Fully associative cache (FIFO / LRU / clock) with compulsory/capacity
// miss classification against a stored key history.
// ----------------------------------------------------------------------------
// Sequence from request accept to result: a hit goes from lookup straight to
// the result; a miss scans the key history (H = keys in history, up to 256),
// classifies the miss and, under clock when full, walks the hand at most one lap.
// Throughput: one request at a time; the history scan (one RAM read per
// cycle on a single read port) sets the miss time.
// Reset: async active low; clears counts, history fill, hand and ref bits;
// policy FIFO, 16 ways. Entry and history RAM contents are not cleared.
module assoc_cache_replacement_miss_classifier import acrmc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KEY_W-1:0]      key_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output logic [1:0]            miss_kind_o,
  output logic [TOTAL_W-1:0]    compulsory_count_o,
  output logic [TOTAL_W-1:0]    capacity_count_o,
  output logic                  history_full_o
);

  state_e                state_q, state_d;
  policy_e               policy_q;
  logic [WAY_CNT_W-1:0]  ways_q;
  logic [WAY_CNT_W-1:0]  ways_eff;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [HIST_CNT_W-1:0] hcnt_q, hcnt_d;
  logic [HIST_CNT_W-1:0] idx_q, idx_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic                  seen_q, seen_d;
  logic [WAY_CNT_W-1:0]  step_q, step_d;
  logic [TOTAL_W-1:0]    comp_q, comp_d, cap_q, cap_d;
  logic                  hit_q, hit_d, hfull_q, hfull_d;
  miss_kind_e            kind_q, kind_d;
  logic                  hist_we;
  logic [KEY_W-1:0]      hist_rdata;
  way_cmd_t              wcmd;
  way_sts_t              wsts;

  // config: always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIFO;
      ways_q   <= WAY_CNT_W'(MAX_WAYS);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_POLICY: policy_q <= policy_e'(cfg_data_i[1:0]);
        REG_WAYS:   ways_q   <= cfg_data_i[WAY_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // out of range way counts clamp to 1..MAX_WAYS
  assign ways_eff = (ways_q == '0) ? WAY_CNT_W'(1) :
                    (ways_q > WAY_CNT_W'(MAX_WAYS)) ? WAY_CNT_W'(MAX_WAYS) : ways_q;

  // key history: one write (new compulsory key), one scan read per cycle
  acrmc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hcnt_q[HIST_AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (idx_q[HIST_AW-1:0]),
    .rdata_o (hist_rdata)
  );

  acrmc_ways u_ways (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (wcmd),
    .sts_o  (wsts)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RESULT);

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    hcnt_d    = hcnt_q;
    idx_d     = idx_q;
    cmp_vld_d = 1'b0;
    seen_d    = seen_q;
    step_d    = step_q;
    comp_d    = comp_q;
    cap_d     = cap_q;
    hit_d     = hit_q;
    hfull_d   = hfull_q;
    kind_d    = kind_q;
    hist_we   = 1'b0;
    wcmd.op   = WOP_NONE;
    wcmd.key  = key_q;
    wcmd.ways = ways_eff;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = key_i;
          wcmd.op = WOP_TRIM;   // drop entries beyond a shrunk way count
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (wsts.found) begin
          hit_d   = 1'b1;
          kind_d  = KIND_HIT;
          hfull_d = 1'b0;
          if (policy_q == POL_LRU) wcmd.op = WOP_LRU_HIT;
          else if (policy_q == POL_CLOCK) wcmd.op = WOP_REF_SET;
          state_d = ST_RESULT;
        end else begin
          idx_d   = '0;
          state_d = ST_HIST;
        end
      end
      ST_HIST: begin
        // compare data for the address issued last cycle, issue the next
        if (cmp_vld_q && hist_rdata == key_q) begin
          seen_d  = 1'b1;
          state_d = ST_MISS;
        end else if (idx_q < hcnt_q) begin
          idx_d     = idx_q + 1'b1;
          cmp_vld_d = 1'b1;
        end else begin
          seen_d  = 1'b0;
          state_d = ST_MISS;
        end
      end
      ST_MISS: begin
        hit_d   = 1'b0;
        hfull_d = 1'b0;
        if (seen_q) begin
          kind_d = KIND_CAP;
          if (~&cap_q) cap_d = cap_q + 1'b1;
        end else begin
          kind_d = KIND_COMP;
          if (~&comp_q) comp_d = comp_q + 1'b1;
          if (hcnt_q < HIST_CNT_W'(HIST_DEPTH)) begin
            hist_we = 1'b1;
            hcnt_d  = hcnt_q + 1'b1;
          end else begin
            hfull_d = 1'b1;
          end
        end
        step_d = '0;
        if (!wsts.full) begin
          wcmd.op = WOP_FILL;
          state_d = ST_RESULT;
        end else if (policy_q == POL_CLOCK) begin
          state_d = ST_CLOCK;
        end else begin
          wcmd.op = WOP_SHIFT_IN;
          state_d = ST_RESULT;
        end
      end
      ST_CLOCK: begin
        // second chance: clear set bits as the hand passes, at most one lap
        if (step_q < ways_eff && wsts.hand_ref) begin
          wcmd.op = WOP_CLK_STEP;
          step_d  = step_q + 1'b1;
        end else begin
          wcmd.op = WOP_CLK_PLACE;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hcnt_q    <= '0;
      cmp_vld_q <= 1'b0;
      comp_q    <= '0;
      cap_q     <= '0;
    end else begin
      state_q   <= state_d;
      hcnt_q    <= hcnt_d;
      cmp_vld_q <= cmp_vld_d;
      comp_q    <= comp_d;
      cap_q     <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    idx_q   <= idx_d;
    seen_q  <= seen_d;
    step_q  <= step_d;
    hit_q   <= hit_d;
    hfull_q <= hfull_d;
    kind_q  <= kind_d;
  end

  assign hit_o              = hit_q;
  assign miss_kind_o        = kind_q;
  assign compulsory_count_o = comp_q;
  assign capacity_count_o   = cap_q;
  assign history_full_o     = hfull_q;

  a_hit_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == (miss_kind_o == KIND_HIT)))
    else $error("hit flag and miss kind disagree");

  a_hfull_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && history_full_o) |-> (miss_kind_o == KIND_COMP))
    else $error("history full flagged on non-compulsory result");

  a_hcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= HIST_CNT_W'(HIST_DEPTH))
    else $error("history count past depth");

  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!out_valid_o && !in_ready_o))
    else $error("result or accept right after an accept");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the associative cache miss classifier.
// A directed table runs first, then random key streams run under every
// policy and several way counts. A local copy of the cache and the key
// history predicts each result, and results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import acrmc_pkg::*;

  // Expected response of one lookup
  typedef struct packed {
    logic             hit;
    miss_kind_e       kind;
    logic [TOTAL_W-1:0] comp;
    logic [TOTAL_W-1:0] cap;
    logic             hfull;
  } lookup_res_t;

  // One line of the directed table: a register write or a key
  typedef struct {
    bit                    is_cfg;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [KEY_W-1:0]      key;
    bit                    typed;
    lookup_res_t           want;
  } dir_row_t;

  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN_WAIT = 300;
  localparam int N_PHASES   = 8;
  localparam int PHASE_KEYS = 244;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [KEY_W-1:0]      key_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  hit_o;
  logic [1:0]            miss_kind_o;
  logic [TOTAL_W-1:0]    compulsory_count_o;
  logic [TOTAL_W-1:0]    capacity_count_o;
  logic                  history_full_o;

  assoc_cache_replacement_miss_classifier dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow cache: ways, reference bits, hand, key history and totals
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0]      way_key [MAX_WAYS];
  bit                    ref_bit [MAX_WAYS];
  int unsigned           n_valid, hand, hist_n;
  logic [KEY_W-1:0]      hist_key [HIST_DEPTH];
  logic [TOTAL_W-1:0]    comp_total, cap_total;
  policy_e               cur_policy;
  logic [CFG_DATA_W-1:0] cur_ways;

  lookup_res_t pending_q[$];   // expected results, oldest first

  // Looks up one key, updates the shadow state and returns the result
  function automatic lookup_res_t classify(logic [KEY_W-1:0] k);
    lookup_res_t r;
    int unsigned ways, pos, i;
    bit found, seen;
    ways  = (cur_ways == 0) ? 1 : (cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways;
    found = 1'b0;
    seen  = 1'b0;
    pos   = 0;
    r     = '0;
    r.kind = KIND_HIT;
    // shrinking the way count drops the upper entries
    if (n_valid > ways) n_valid = ways;
    if (hand >= ways) hand = 0;
    for (i = 0; i < n_valid; i++)
      if (!found && way_key[i] == k) begin
        found = 1'b1;
        pos   = i;
      end
    if (found) begin
      if (cur_policy == POL_LRU) begin
        for (i = pos; i + 1 < n_valid; i++) way_key[i] = way_key[i+1];
        way_key[n_valid-1] = k;
      end else if (cur_policy == POL_CLOCK) begin
        ref_bit[pos] = 1'b1;
      end
    end else begin
      for (i = 0; i < hist_n; i++)
        if (hist_key[i] == k) seen = 1'b1;
      if (seen) begin
        r.kind = KIND_CAP;
        if (cap_total != '1) cap_total++;
      end else begin
        r.kind = KIND_COMP;
        if (comp_total != '1) comp_total++;
        if (hist_n < HIST_DEPTH) begin
          hist_key[hist_n] = k;
          hist_n++;
        end else begin
          r.hfull = 1'b1;   // history full: key stays unrecorded
        end
      end
      if (n_valid < ways) begin
        way_key[n_valid] = k;
        ref_bit[n_valid] = 1'b0;
        n_valid++;
      end else if (cur_policy == POL_CLOCK) begin
        // second chance: clear set bits until a clear one is under the hand
        for (i = 0; i < ways && ref_bit[hand]; i++) begin
          ref_bit[hand] = 1'b0;
          hand = (hand + 1) % ways;
        end
        way_key[hand] = k;
        ref_bit[hand] = 1'b0;
        hand = (hand + 1) % ways;
      end else begin
        // FIFO, LRU and the spare code drop position 0
        for (i = 0; i + 1 < ways; i++) way_key[i] = way_key[i+1];
        way_key[ways-1] = k;
      end
    end
    r.hit  = found;
    r.comp = comp_total;
    r.cap  = cap_total;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake sampling on the falling edge: everything is stable there
  // --------------------------------------------------------------------------
  bit in_acc, cfg_acc, out_acc;
  int errors;

  always @(negedge clk_i) begin
    lookup_res_t e;
    in_acc  = in_valid_i && in_ready_o;
    cfg_acc = cfg_valid_i && cfg_ready_o;
    out_acc = out_valid_o && out_ready_i;
    if (out_acc) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: hit=%0b kind=%0d", hit_o, miss_kind_o);
      end else begin
        e = pending_q.pop_front();
        if (hit_o !== e.hit || miss_kind_o !== e.kind || compulsory_count_o !== e.comp ||
            capacity_count_o !== e.cap || history_full_o !== e.hfull) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp hit=%0b kind=%0d comp=%0d cap=%0d hf=%0b",
                     e.hit, e.kind, e.comp, e.cap, e.hfull);
            $display("          got hit=%0b kind=%0d comp=%0d cap=%0d hf=%0b",
                     hit_o, miss_kind_o, compulsory_count_o, capacity_count_o,
                     history_full_o);
          end
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch without any handshake
  int quiet_cycles;
  always @(posedge clk_i) begin
    if (in_acc || cfg_acc || out_acc) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("[assoc_cache_replacement_miss_classifier] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stall, plus one long hold to back up the input
  // --------------------------------------------------------------------------
  int stall_pct;
  int hold_req;
  int hold_left;
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  int gap_pct;

  // Offers one key; valid stays up across back-to-back requests
  task automatic send_key(logic [KEY_W-1:0] k, bit typed, lookup_res_t want);
    lookup_res_t r;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_i      <= k;
    r = classify(k);
    pending_q.push_back(typed ? want : r);
    do @(posedge clk_i); while (!in_acc);
  endtask

  // Register write, only once every result is back
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_acc);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_POLICY) cur_policy = policy_e'(d[1:0]);
    else cur_ways = d;
  endtask

  dir_row_t dir_q[$];

  function automatic void add_cfg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    dir_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: d, key: '0, typed: 1'b0, want: '0};
    dir_q.push_back(row);
  endfunction

  function automatic void add_key(logic [KEY_W-1:0] k, bit typed = 1'b0,
                                  lookup_res_t want = '0);
    dir_row_t row;
    row = '{is_cfg: 1'b0, idx: REG_POLICY, data: '0, key: k, typed: typed, want: want};
    dir_q.push_back(row);
  endfunction

  logic [KEY_W-1:0] key_pool [32];

  initial begin
    int p, n, span;
    logic [KEY_W-1:0] k;
    policy_e pol_tab [N_PHASES];
    logic [CFG_DATA_W-1:0] ways_tab [N_PHASES];

    pol_tab  = '{POL_FIFO, POL_LRU, POL_CLOCK, POL_SPARE,
                 POL_LRU, POL_CLOCK, POL_FIFO, POL_CLOCK};
    ways_tab = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd16, 5'd7, 5'd2};
    errors = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    n_valid = 0;
    hand = 0;
    hist_n = 0;
    comp_total = '0;
    cap_total = '0;
    cur_policy = POL_FIFO;
    cur_ways = 5'd16;
    foreach (ref_bit[i]) ref_bit[i] = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Only the opening rows carry a hand-typed result.
    add_key(32'h0, 1'b1, '{1'b0, KIND_COMP, 32'd1, 32'd0, 1'b0});
    add_key(32'h0, 1'b1, '{1'b1, KIND_HIT, 32'd1, 32'd0, 1'b0});
    add_key(32'hFFFF_FFFF, 1'b1, '{1'b0, KIND_COMP, 32'd2, 32'd0, 1'b0});
    add_cfg(REG_POLICY, POL_LRU);
    add_cfg(REG_WAYS, 5'd2);
    add_key(32'h0);              // LRU hit moves 0 to the back
    add_key(32'h5);              // evicts all-ones
    add_key(32'hFFFF_FFFF);      // capacity miss
    add_key(32'h0);
    add_cfg(REG_POLICY, POL_CLOCK);
    add_cfg(REG_WAYS, 5'd3);
    add_key(32'h7);
    add_key(32'h0);              // sets a reference bit
    add_key(32'h8);
    add_key(32'h9);              // hand skips the referenced way
    add_key(32'h0);
    add_cfg(REG_POLICY, POL_SPARE);  // unused code acts as FIFO
    add_cfg(REG_WAYS, 5'd0);         // zero ways acts as one
    add_key(32'h1);
    add_key(32'h2);
    add_key(32'h1);
    add_cfg(REG_WAYS, 5'd31);        // clamps to the way maximum
    add_key(32'hA5A5_A5A5);
    add_key(32'h5A5A_5A5A);

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) write_reg(dir_q[i].idx, dir_q[i].data);
      else send_key(dir_q[i].key, dir_q[i].typed, dir_q[i].want);
    end

    // Random phases: each sets policy and ways, then streams keys drawn
    // mostly from a small pool (hits and capacity misses), the rest fresh
    // so the history eventually fills.
    for (p = 0; p < N_PHASES; p++) begin
      write_reg(REG_POLICY, pol_tab[p]);
      write_reg(REG_WAYS, ways_tab[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 66; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 66; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      if (p == 4) hold_req = 400;
      span = (ways_tab[p] > 27) ? 31 : ways_tab[p] + 4;
      for (n = 0; n < PHASE_KEYS; n++) begin
        if ($urandom_range(99) < 20) k = $urandom;
        else k = key_pool[$urandom_range(span)];
        send_key(k, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) $display("[assoc_cache_replacement_miss_classifier] OK");
    else $display("[assoc_cache_replacement_miss_classifier] ERROR");
    $finish;
  end

endmodule
